[hw/rtl/flex_wrap_line_layout_top_assert.svh]
// Assertion macros shared by the layout block
`ifndef FLEX_WRAP_LINE_LAYOUT_TOP_ASSERT_SVH
`define FLEX_WRAP_LINE_LAYOUT_TOP_ASSERT_SVH
`define FWL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FWL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/fwl_pkg.sv]
// ---------------------------------------------------------------------------
// fwl_pkg
// Types and constants of the flex wrap line layout block.
// ---------------------------------------------------------------------------
`default_nettype none
package fwl_pkg;
    localparam int unsigned Y_W = 24;
    localparam logic [Y_W-1:0] Y_MAX = 24'hFFFFFF;
    localparam int unsigned CFG_CONTAINER_WIDTH = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_LONE,
        ST_ADD,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;
endpackage
`default_nettype wire

[hw/rtl/fwl_cell.sv]
// ---------------------------------------------------------------------------
// fwl_cell
// One slot of the line buffer: holds a width and flex weight; loads from the
// tail or passes its word to the neighbor toward the head.
// ---------------------------------------------------------------------------
`default_nettype none
module fwl_cell (
    input  wire logic             i_clk,
    input  wire fwl_pkg::t_cell_ctl i_ctl,
    input  wire logic             i_sel,
    input  wire logic [15:0]      i_new_w,
    input  wire logic [7:0]       i_new_f,
    input  wire logic [15:0]      i_nb_w,
    input  wire logic [7:0]       i_nb_f,
    output logic [15:0]           o_w,
    output logic [7:0]            o_f
);
    import fwl_pkg::*;
    logic [15:0] r_w;
    logic [7:0]  r_f;
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_w <= i_nb_w;
            r_f <= i_nb_f;
        end else if (i_ctl.load && i_sel) begin
            r_w <= i_new_w;
            r_f <= i_new_f;
        end
    end
    assign o_w = r_w;
    assign o_f = r_f;
endmodule
`default_nettype wire

[hw/rtl/fwl_div.sv]
// ---------------------------------------------------------------------------
// fwl_div
// Restoring divider, one quotient bit per cycle (17-bit numerator).
// ---------------------------------------------------------------------------
`default_nettype none
module fwl_div #(
    parameter int unsigned DW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [16:0]   i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [16:0]        o_quot
);
    import fwl_pkg::*;
    logic [16:0]   r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic [DW:0]   w_tr;
    assign w_tr = {r_rem[DW-1:0], r_q[16]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd17;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_tr >= {1'b0, r_den}) begin
                r_rem <= w_tr - {1'b0, r_den};
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= w_tr;
                r_q   <= {r_q[15:0], 1'b0};
            end
        end
    end
    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[hw/rtl/flex_wrap_line_layout_top.sv]
// ---------------------------------------------------------------------------
// flex_wrap_line_layout_top
// Row flexbox line wrapping over a chain of line buffer cells.
// ---------------------------------------------------------------------------
// A child is accepted in ST_IDLE and joins the open line in the next cycle.
// A child that closes the open line starts the close, waits for the serial
// divide (skipped when the flex total is zero) and then sends each buffered
// child, since the cell chain shifts one word toward the head each cycle that
// the output is not stalled; every word is held until taken. A too wide child
// is placed alone in a step of its own. A last child adds a step to start its
// own line close plus that close, and a step to clear the layout. Items are
// taken one at a time.
`default_nettype none
module flex_wrap_line_layout_top #(
    parameter int unsigned LINE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_child_width,
    input  wire logic [15:0] i_child_height,
    input  wire logic [7:0]  i_flex_weight,
    input  wire logic        i_last_child,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_child_index,
    output logic [23:0]      o_row_y,
    output logic [15:0]      o_final_width,
    output logic             o_last_of_run,
    output logic             o_layout_done,
    output logic [23:0]      o_total_height
);
    import fwl_pkg::*;
    `include "flex_wrap_line_layout_top_assert.svh"

    localparam int unsigned FW = $clog2(LINE_DEPTH + 1);
    localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int unsigned TW = $clog2(LINE_DEPTH * 255 + 1);

    logic [15:0] r_cw;
    logic [15:0] r_w, r_h, n_w, n_h;
    logic [7:0]  r_f, n_f;
    logic        r_last, n_last;
    logic [FW-1:0] r_fill, n_fill;
    logic [15:0] r_start, n_start, r_cnt, n_cnt;
    logic [16:0] r_used, n_used;
    logic [TW-1:0] r_ftot, n_ftot;
    logic [23:0] r_y, n_y;
    logic [15:0] r_maxh, n_maxh;
    logic [15:0] r_per, n_per;
    logic [FW-1:0] r_k, n_k;
    t_state r_st, n_st;
    logic        r_ov, n_ov;
    logic [15:0] r_oi, n_oi, r_ow, n_ow;
    logic [23:0] r_oy, n_oy, r_ot, n_ot;
    logic        r_ol, n_ol, r_od, n_od;
    logic        r_pend, n_pend;

    logic        w_cfg_wr, w_acc, w_obusy, w_div_start, w_div_busy;
    logic [16:0] w_spare, w_quot;
    t_cell_ctl   w_ctl;
    logic [15:0] w_cw [LINE_DEPTH+1];
    logic [7:0]  w_cf [LINE_DEPTH+1];

    assign pready   = 1'b1;
    assign prdata   = {16'd0, r_cw};
    assign w_cfg_wr = psel && penable && pwrite && (paddr == 1'(CFG_CONTAINER_WIDTH));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cw <= '0;
        else if (w_cfg_wr) r_cw <= pwdata[15:0];
    end

    assign w_acc   = i_valid && o_ready;
    assign w_obusy = r_ov && !i_ready;
    assign w_spare = ({1'b0, r_cw} >= r_used) ? {1'b0, r_cw} - r_used : 17'd0;

    fwl_div #(.DW(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_spare), .i_den(r_ftot), .o_busy(w_div_busy), .o_quot(w_quot)
    );

    assign w_cw[LINE_DEPTH] = '0;
    assign w_cf[LINE_DEPTH] = '0;
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        fwl_cell u_cell (
            .i_clk(i_clk), .i_ctl(w_ctl), .i_sel(r_fill[AW-1:0] == AW'(g)),
            .i_new_w(r_w), .i_new_f(r_f), .i_nb_w(w_cw[g+1]), .i_nb_f(w_cf[g+1]),
            .o_w(w_cw[g]), .o_f(w_cf[g])
        );
    end

    logic [23:0] w_prod;
    logic [24:0] w_ysum;
    logic [23:0] w_yadd;
    logic        w_close, w_lone;
    assign w_prod  = 24'(w_cf[0]) * 24'(r_per);
    assign w_close = (r_fill != '0) && ((r_used + 17'(r_w) > {1'b0, r_cw})
                     || (r_fill >= FW'(LINE_DEPTH)));
    assign w_lone  = (r_w > r_cw);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (w_acc) n_st = ST_ADD;
            ST_ADD: begin
                if (w_close) n_st = ST_DIV;
                else if (r_fill == '0 && w_lone) n_st = ST_LONE;
                else if (r_last) n_st = ST_FINAL;
                else n_st = ST_IDLE;
            end
            ST_DIV:   if (!w_div_busy && !w_div_start) n_st = ST_EMIT;
            ST_EMIT:  if (!w_obusy && r_k == r_fill - FW'(1))
                          n_st = r_pend ? ST_ADD : ST_FINAL;
            ST_LONE:  if (!w_obusy) n_st = r_last ? ST_FINAL : ST_IDLE;
            ST_FINAL: if (!w_obusy) n_st = (r_fill != '0) ? ST_DIV : ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_w = r_w; n_h = r_h; n_f = r_f; n_last = r_last;
        n_fill = r_fill; n_start = r_start; n_cnt = r_cnt; n_used = r_used;
        n_ftot = r_ftot; n_y = r_y; n_maxh = r_maxh; n_per = r_per; n_k = r_k;
        n_ov = r_ov && !i_ready; n_oi = r_oi; n_ow = r_ow; n_oy = r_oy;
        n_ot = r_ot; n_ol = r_ol; n_od = r_od;
        w_ctl = '0;
        w_div_start = 1'b0;
        w_ysum = 25'(r_y) + 25'(r_maxh);
        w_yadd = w_ysum[24] ? Y_MAX : w_ysum[23:0];
        o_ready = (r_st == ST_IDLE);
        case (r_st)
            ST_IDLE: if (w_acc) begin
                n_w = i_child_width; n_h = i_child_height;
                n_f = i_flex_weight; n_last = i_last_child;
            end
            ST_ADD: begin
                if (w_close) begin
                    w_div_start = (r_ftot != '0);
                    n_k = '0;
                end else if (!(r_fill == '0 && w_lone)) begin
                    if (r_fill == '0) n_start = r_cnt;
                    w_ctl.load = 1'b1;
                    n_fill = r_fill + FW'(1);
                    n_used = r_used + 17'(r_w);
                    n_ftot = r_ftot + TW'(r_f);
                    if (r_h > r_maxh) n_maxh = r_h;
                    n_cnt = r_cnt + 16'd1;
                end
            end
            ST_DIV: if (!w_div_busy) n_per = (r_ftot == '0) ? 16'd0 : w_quot[15:0];
            ST_EMIT: if (!w_obusy) begin
                w_ctl.shift = 1'b1;
                n_ov = 1'b1; n_oi = r_start + 16'(r_k); n_oy = r_y;
                n_ow = w_cw[0] + w_prod[15:0];
                n_ol = 1'b0; n_od = 1'b0; n_ot = '0;
                n_k = r_k + FW'(1);
                if (r_k == r_fill - FW'(1)) begin
                    n_y = w_yadd;
                    n_fill = '0; n_used = '0; n_ftot = '0; n_maxh = '0;
                    if (r_pend) begin
                        // displacing child still to place: ends the run only
                        // if it neither goes alone nor closes the layout
                        n_ol = !r_last && !w_lone;
                    end else begin
                        n_ol = 1'b1; n_od = 1'b1; n_ot = w_yadd;
                    end
                end
            end
            ST_LONE: if (!w_obusy) begin
                n_ov = 1'b1; n_oi = r_cnt; n_oy = r_y; n_ow = r_cw;
                n_ot = '0; n_od = 1'b0;
                w_ysum = 25'(r_y) + 25'(r_h);
                n_y = w_ysum[24] ? Y_MAX : w_ysum[23:0];
                n_cnt = r_cnt + 16'd1;
                n_ol = 1'b1;
                if (r_last) begin
                    n_od = 1'b1; n_ot = w_ysum[24] ? Y_MAX : w_ysum[23:0];
                end
            end
            ST_FINAL: if (!w_obusy) begin
                if (r_fill != '0) begin
                    w_div_start = (r_ftot != '0);
                    n_k = '0;
                end else begin
                    n_start = '0; n_cnt = '0; n_y = '0; n_last = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (r_st == ST_ADD && w_close) n_pend = 1'b1;
        else if (r_st == ST_FINAL && !w_obusy) n_pend = 1'b0;
        else if (r_st == ST_EMIT && !w_obusy && r_k == r_fill - FW'(1)) n_pend = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov <= 1'b0; r_fill <= '0; r_start <= '0;
            r_cnt <= '0; r_used <= '0; r_ftot <= '0; r_y <= '0; r_maxh <= '0;
            r_k <= '0; r_last <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov; r_fill <= n_fill; r_start <= n_start;
            r_cnt <= n_cnt; r_used <= n_used; r_ftot <= n_ftot; r_y <= n_y;
            r_maxh <= n_maxh; r_k <= n_k; r_last <= n_last; r_pend <= n_pend;
        end
    end
    always_ff @(posedge i_clk) begin
        r_w <= n_w; r_h <= n_h; r_f <= n_f; r_per <= n_per;
        r_oi <= n_oi; r_ow <= n_ow; r_oy <= n_oy; r_ot <= n_ot;
        r_ol <= n_ol; r_od <= n_od;
    end

    assign o_valid = r_ov;
    assign o_child_index = r_oi;
    assign o_row_y = r_oy;
    assign o_final_width = r_ow;
    assign o_last_of_run = r_ol;
    assign o_layout_done = r_od;
    assign o_total_height = r_ot;

    `FWL_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !w_div_busy)
    `FWL_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= FW'(LINE_DEPTH))
    `FWL_ASSERT_NXT(a_done_last, i_clk, i_rst_n, r_ov && i_ready && r_od, !r_ov)
endmodule
`default_nettype wire
